// ===== sv/stp_pkg.sv =====
// Shared types, field codes and small lookup functions for the scan telegram parser.
// Used by stp_front, stp_queue, stp_back and scan_telegram_parser; depends on nothing.
`default_nettype none

package stp_pkg;

	// Limits of the telegram format.
	localparam int MAX_POINTS  = 1024;
	localparam int STRING_MAX  = 16;
	localparam int TRAILER_LEN = 11;

	// Widths derived from the limits.
	localparam int ELEM_W = $clog2(MAX_POINTS + 1);
	localparam int SLEN_W = $clog2(STRING_MAX);
	localparam int TPOS_W = $clog2(TRAILER_LEN);

	// Depth of the queue between front and back (power of two).
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Control characters.
	localparam logic [7:0] STX_CODE   = 8'h02;
	localparam logic [7:0] ETX_CODE   = 8'h03;
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] ZERO_CODE  = 8'h30;

	// Result kinds.
	localparam logic [2:0] KIND_NUM      = 3'd0;
	localparam logic [2:0] KIND_CHAR     = 3'd1;
	localparam logic [2:0] KIND_STR_END  = 3'd2;
	localparam logic [2:0] KIND_FRAME    = 3'd3;
	localparam logic [2:0] KIND_ERR      = 3'd4;

	// Field positions that need special handling.
	localparam logic [4:0] FLD_CMD_TYPE    = 5'd0;
	localparam logic [4:0] FLD_CMD         = 5'd1;
	localparam logic [4:0] FLD_STATUS      = 5'd5;
	localparam logic [4:0] FLD_INPUTS      = 5'd10;
	localparam logic [4:0] FLD_OUTPUTS     = 5'd11;
	localparam logic [4:0] FLD_ENCODERS    = 5'd15;
	localparam logic [4:0] FLD_CHANNELS    = 5'd16;
	localparam logic [4:0] FLD_CONTENT     = 5'd17;
	localparam logic [4:0] FLD_POINT_COUNT = 5'd22;
	localparam logic [4:0] FLD_POINTS      = 5'd23;
	localparam logic [4:0] FLD_TRAILER     = 5'd24;
	localparam logic [4:0] FLD_ETX         = 5'd25;

	// One received byte after classification.
	typedef struct packed {
		logic [7:0] code;
		logic       is_hex;
		logic [3:0] digit;
		logic       is_space;
		logic       is_stx;
		logic       is_etx;
	} cls_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic valid;
		cls_t cls;
	} qhead_t;

	// Mask that truncates a numeric token to the width of its field.
	function automatic logic [31:0] field_mask(input logic [4:0] fid);
		logic [31:0] m;
		m = '0;
		if (fid inside {5'd10, 5'd11})
			m = 32'h0000_00FF;
		else if (fid inside {5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd12, 5'd15, 5'd16,
			5'd21, 5'd22, 5'd23})
			m = 32'h0000_FFFF;
		else if (fid inside {5'd4, 5'd8, 5'd9, 5'd13, 5'd14, 5'd18, 5'd19, 5'd20})
			m = 32'hFFFF_FFFF;
		return m;
	endfunction

	// The trailer alternates zero digits and spaces.
	function automatic logic [7:0] trailer_char(input logic [TPOS_W-1:0] pos);
		return pos[0] ? SPACE_CODE : ZERO_CODE;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stp_front.sv =====
// Front end of the scan telegram parser: takes in bytes and classifies them.
// Depends on stp_pkg; feeds stp_queue.
`default_nettype none

module stp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    byte_in,
	input  wire logic          q_full,
	output logic               q_push,
	output stp_pkg::cls_t      q_data
);

	logic          v_s1;
	stp_pkg::cls_t cls_s1;
	stp_pkg::cls_t cls_new;
	logic          take;

	always_comb begin
		cls_new          = '0;
		cls_new.code     = byte_in;
		cls_new.is_space = (byte_in == stp_pkg::SPACE_CODE);
		cls_new.is_stx   = (byte_in == stp_pkg::STX_CODE);
		cls_new.is_etx   = (byte_in == stp_pkg::ETX_CODE);
		if (byte_in inside {[8'h30:8'h39]}) begin
			cls_new.is_hex = 1'b1;
			cls_new.digit  = byte_in[3:0];
		end else if (byte_in inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			cls_new.is_hex = 1'b1;
			cls_new.digit  = 4'(byte_in[2:0] + 3'd1) + 4'd8;
		end
	end

	assign in_ready = !v_s1 || !q_full;
	assign take     = in_valid && in_ready;
	assign q_push   = v_s1 && !q_full;
	assign q_data   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take || (v_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls_new;
		end
	end

endmodule

`default_nettype wire

// ===== sv/stp_queue.sv =====
// Short queue of classified bytes between the parser front and back ends.
// Depends on stp_pkg.
`default_nettype none

module stp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire stp_pkg::cls_t push_data,
	output logic               full,
	input  wire logic          pop,
	output stp_pkg::qhead_t    head
);

	stp_pkg::cls_t                  slot_q [stp_pkg::QUEUE_DEPTH];
	logic [stp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [stp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [stp_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (count_q == stp_pkg::QCNT_W'(stp_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cls   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/stp_back.sv =====
// Back end of the scan telegram parser: field sequencing, token decode and result register.
// Depends on stp_pkg; takes classified bytes from stp_queue.
`default_nettype none

module stp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire stp_pkg::qhead_t head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         result_kind,
	output logic [4:0]         field_id,
	output logic [9:0]         elem_index,
	output logic [31:0]        value
);

	localparam int ELEM_W = stp_pkg::ELEM_W;
	localparam int SLEN_W = stp_pkg::SLEN_W;
	localparam int TPOS_W = stp_pkg::TPOS_W;

	// Parser state.
	logic              frame_q;
	logic [4:0]        phase_q;
	logic [31:0]       acc_q;
	logic              dig_q;
	logic [ELEM_W-1:0] elem_q;
	logic [ELEM_W-1:0] points_q;
	logic [SLEN_W-1:0] slen_q;
	logic [TPOS_W-1:0] tpos_q;

	// Result register.
	logic              out_valid_q;
	logic [2:0]        kind_q;
	logic [4:0]        fid_q;
	logic [9:0]        idx_q;
	logic [31:0]       val_q;

	// Next-state values.
	logic              frame_d;
	logic [4:0]        phase_d;
	logic [31:0]       acc_d;
	logic              dig_d;
	logic [ELEM_W-1:0] elem_d;
	logic [ELEM_W-1:0] points_d;
	logic [SLEN_W-1:0] slen_d;
	logic [TPOS_W-1:0] tpos_d;

	logic              go;
	logic              go_wait;
	logic [4:0]        go_phase;
	logic              start;
	logic              fail;
	logic              emit;
	logic [2:0]        e_kind;
	logic [9:0]        e_idx;
	logic [31:0]       e_val;
	logic [31:0]       num_val;
	logic [ELEM_W-1:0] elem_inc;
	stp_pkg::cls_t     c;

	assign c        = head.cls;
	assign pop      = head.valid && (!out_valid_q || out_ready);
	assign num_val  = acc_q & stp_pkg::field_mask(phase_q);
	assign elem_inc = elem_q + ELEM_W'(1);

	always_comb begin
		frame_d  = frame_q;
		phase_d  = phase_q;
		acc_d    = acc_q;
		dig_d    = dig_q;
		elem_d   = elem_q;
		points_d = points_q;
		slen_d   = slen_q;
		tpos_d   = tpos_q;
		go       = 1'b0;
		go_wait  = 1'b0;
		go_phase = phase_q;
		start    = 1'b0;
		fail     = 1'b0;
		emit     = 1'b0;
		e_kind   = stp_pkg::KIND_NUM;
		e_idx    = elem_q[9:0];
		e_val    = {24'd0, c.code};

		if (!frame_q) begin
			// Hunting for the start of a telegram; everything else is dropped.
			if (c.is_stx) begin
				start = 1'b1;
			end
		end else if (phase_q == stp_pkg::FLD_CMD_TYPE || phase_q == stp_pkg::FLD_CMD ||
			phase_q == stp_pkg::FLD_CONTENT) begin
			if (c.is_space) begin
				emit     = 1'b1;
				e_kind   = stp_pkg::KIND_STR_END;
				e_idx    = '0;
				e_val    = 32'(slen_q);
				go       = 1'b1;
				go_phase = phase_q + 5'd1;
			end else if (c.is_stx || c.is_etx ||
				slen_q >= SLEN_W'(stp_pkg::STRING_MAX - 1)) begin
				fail = 1'b1;
			end else begin
				emit   = 1'b1;
				e_kind = stp_pkg::KIND_CHAR;
				e_idx  = 10'(slen_q);
				slen_d = slen_q + SLEN_W'(1);
			end
		end else if (phase_q == stp_pkg::FLD_TRAILER) begin
			if (c.code == stp_pkg::trailer_char(tpos_q)) begin
				if (tpos_q == TPOS_W'(stp_pkg::TRAILER_LEN - 1)) begin
					go       = 1'b1;
					go_phase = stp_pkg::FLD_ETX;
				end else begin
					tpos_d = tpos_q + TPOS_W'(1);
				end
			end else begin
				fail = 1'b1;
			end
		end else if (phase_q == stp_pkg::FLD_ETX) begin
			if (c.is_etx) begin
				emit    = 1'b1;
				e_kind  = stp_pkg::KIND_FRAME;
				e_idx   = '0;
				e_val   = 32'(points_q);
				go      = 1'b1;
				go_wait = 1'b1;
			end else begin
				fail = 1'b1;
			end
		end else begin
			// Numeric hex field.
			if (c.is_hex) begin
				acc_d = {acc_q[27:0], c.digit};
				dig_d = 1'b1;
			end else if (!c.is_space || !dig_q) begin
				fail = 1'b1;
			end else begin
				emit   = 1'b1;
				e_kind = stp_pkg::KIND_NUM;
				e_val  = num_val;
				acc_d  = '0;
				dig_d  = 1'b0;
				slen_d = '0;
				case (phase_q)
					stp_pkg::FLD_STATUS, stp_pkg::FLD_INPUTS, stp_pkg::FLD_OUTPUTS: begin
						if (elem_q == ELEM_W'(1)) begin
							go       = 1'b1;
							go_phase = phase_q + 5'd1;
						end else begin
							elem_d = elem_inc;
						end
					end
					stp_pkg::FLD_ENCODERS: begin
						if (elem_q == '0) begin
							if (num_val == '0) begin
								go       = 1'b1;
								go_phase = stp_pkg::FLD_CHANNELS;
							end else begin
								elem_d = ELEM_W'(1);
							end
						end else if (elem_q == ELEM_W'(2)) begin
							go       = 1'b1;
							go_phase = stp_pkg::FLD_CHANNELS;
						end else begin
							elem_d = elem_inc;
						end
					end
					stp_pkg::FLD_POINT_COUNT: begin
						// A rejected count is reported with the count itself.
						if (num_val > 32'(stp_pkg::MAX_POINTS)) begin
							fail  = 1'b1;
							e_val = num_val;
						end else begin
							points_d = ELEM_W'(num_val);
							go       = 1'b1;
							go_phase = (num_val == '0) ? stp_pkg::FLD_TRAILER
								: stp_pkg::FLD_POINTS;
						end
					end
					stp_pkg::FLD_POINTS: begin
						if (elem_inc >= points_q) begin
							go       = 1'b1;
							go_phase = stp_pkg::FLD_TRAILER;
						end else begin
							elem_d = elem_inc;
						end
					end
					default: begin
						go       = 1'b1;
						go_phase = phase_q + 5'd1;
					end
				endcase
			end
		end

		// A format error reports where it happened, then resynchronizes.
		if (fail) begin
			emit   = 1'b1;
			e_kind = stp_pkg::KIND_ERR;
			e_idx  = elem_q[9:0];
			if (c.is_stx) begin
				start = 1'b1;
			end else begin
				go      = 1'b1;
				go_wait = 1'b1;
			end
		end

		if (start) begin
			go       = 1'b1;
			go_wait  = 1'b0;
			go_phase = stp_pkg::FLD_CMD_TYPE;
			points_d = '0;
		end

		if (go) begin
			frame_d = !go_wait;
			phase_d = go_phase;
			acc_d   = '0;
			dig_d   = 1'b0;
			elem_d  = '0;
			slen_d  = '0;
			tpos_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= 1'b0;
			phase_q     <= '0;
			acc_q       <= '0;
			dig_q       <= 1'b0;
			elem_q      <= '0;
			points_q    <= '0;
			slen_q      <= '0;
			tpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				frame_q  <= frame_d;
				phase_q  <= phase_d;
				acc_q    <= acc_d;
				dig_q    <= dig_d;
				elem_q   <= elem_d;
				points_q <= points_d;
				slen_q   <= slen_d;
				tpos_q   <= tpos_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q <= e_kind;
			fid_q  <= phase_q;
			idx_q  <= e_idx;
			val_q  <= e_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign field_id    = fid_q;
	assign elem_index  = idx_q;
	assign value       = val_q;

	// Outside a telegram the per-field counters are always cleared.
	a_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_q |-> (elem_q == '0 && tpos_q == '0 && slen_q == '0))
		else $error("per-field counters not cleared while waiting for STX");

	a_slen_limit: assert property (@(posedge clk) disable iff (!arst_n)
		slen_q <= SLEN_W'(stp_pkg::STRING_MAX - 1))
		else $error("string length beyond limit");

	a_points_limit: assert property (@(posedge clk) disable iff (!arst_n)
		points_q <= ELEM_W'(stp_pkg::MAX_POINTS) && elem_q <= ELEM_W'(stp_pkg::MAX_POINTS))
		else $error("point counters beyond limit");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit && e_kind == stp_pkg::KIND_FRAME) |=> (!frame_q && out_valid_q))
		else $error("frame completion did not return to STX hunt");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (kind_q <= stp_pkg::KIND_ERR && fid_q <= stp_pkg::FLD_ETX))
		else $error("result kind or field id out of range");

endmodule

`default_nettype wire

// ===== sv/scan_telegram_parser.sv =====
// Scan telegram parser: the byte of an accepted beat passes the input register, the queue
// and then the back end's result register before its result beat is valid.
// Throughput one byte per cycle while the result channel takes beats; a stalled result channel
// first fills the input register and the four-entry queue, and only then drops in_ready.
// Reset (arst_n low, asynchronous) empties the queue and result register; the parser waits for STX.
`default_nettype none

// Top level of the ASCII scan telegram parser.
// A byte beat accepted on the input channel is classified by the front end (hex digit,
// space, STX, ETX) and registered. From there it moves into a short queue. The back end
// pops one classified byte per cycle whenever its result register is empty or is being
// drained, walks the fixed field sequence of the telegram and produces at most one result
// beat per byte. Because the queue sits between the two halves, a stall on the result
// channel does not block input beats until the queue fills up.
module scan_telegram_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       result_kind,
	output logic [4:0]       field_id,
	output logic [9:0]       elem_index,
	output logic [31:0]      value
);

	logic            q_full;
	logic            q_push;
	stp_pkg::cls_t   q_data;
	logic            q_pop;
	stp_pkg::qhead_t q_head;

	// Classification and input register.
	stp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.byte_in  (byte_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	// Decoupling queue between the two halves.
	stp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	// Field sequencer, token decoder and result register.
	stp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.field_id    (field_id),
		.elem_index  (elem_index),
		.value       (value)
	);

endmodule

`default_nettype wire

// ===== tb/sv/stp_result_check.sv =====
`timescale 1ns / 100ps
// Result checker for the scan telegram parser: predicts the result beat, if any, of every accepted byte
// and compares it with the result channel. Depends on stp_pkg for field and result codes.

module stp_result_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  byte_in,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [2:0]  result_kind,
	input  wire logic [4:0]  field_id,
	input  wire logic [9:0]  elem_index,
	input  wire logic [31:0] value,
	output int               fail_count,
	output int               pending
);

	import stp_pkg::*;

	// Any field position above the last one means the parser is hunting for STX.
	localparam logic [4:0] FLD_HUNT = 5'd31;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  fid;
		logic [9:0]  idx;
		logic [31:0] val;
	} parse_beat_t;

	parse_beat_t expected_beats[$];
	int          errors;

	// Parser state as the telegram walk sees it.
	logic [4:0]  phase;
	logic [31:0] accum;
	logic [4:0]  ndigits;
	logic [10:0] elem;
	logic [15:0] npoints;
	logic        enc_on;
	logic [4:0]  slen;
	logic [3:0]  tpos;

	function automatic int field_width(input logic [4:0] fid);
		case (fid)
			5'd10, 5'd11: return 8;
			5'd4, 5'd8, 5'd9, 5'd13, 5'd14, 5'd18, 5'd19, 5'd20: return 32;
			default: return 16;
		endcase
	endfunction

	function automatic int hex_digit(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b) - int'("0");
		if (b >= "A" && b <= "F")
			return int'(b) - int'("A") + 10;
		if (b >= "a" && b <= "f")
			return int'(b) - int'("a") + 10;
		return -1;
	endfunction

	function automatic void enter_field(input logic [4:0] ph);
		phase   = ph;
		elem    = '0;
		tpos    = '0;
		accum   = '0;
		ndigits = '0;
		slen    = '0;
	endfunction

	function automatic void begin_telegram();
		npoints = '0;
		enc_on  = 1'b0;
		enter_field(FLD_CMD_TYPE);
	endfunction

	function automatic void expect_beat(input logic [2:0] kind, input logic [4:0] fid,
		input logic [9:0] idx, input logic [31:0] val);
		parse_beat_t beat;
		beat.kind = kind;
		beat.fid  = fid;
		beat.idx  = idx;
		beat.val  = val;
		expected_beats.insert(expected_beats.size(), beat);
	endfunction

	// A format error reports the current position; STX as the culprit restarts at once.
	function automatic void expect_error(input logic [7:0] b, input logic [31:0] val);
		expect_beat(KIND_ERR, phase, elem[9:0], val);
		if (b == STX_CODE)
			begin_telegram();
		else
			enter_field(FLD_HUNT);
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		logic [4:0]  ph;
		logic [31:0] v;
		logic [9:0]  idx;
		int          d;
		int          w;
		ph = phase;
		if (ph > FLD_ETX) begin
			if (b == STX_CODE)
				begin_telegram();
		end else if (ph == FLD_CMD_TYPE || ph == FLD_CMD || ph == FLD_CONTENT) begin
			if (b == SPACE_CODE) begin
				v = 32'(slen);
				enter_field(ph + 5'd1);
				expect_beat(KIND_STR_END, ph, '0, v);
			end else if (b == STX_CODE || b == ETX_CODE || slen >= STRING_MAX - 1) begin
				expect_error(b, 32'(b));
			end else begin
				expect_beat(KIND_CHAR, ph, 10'(slen), 32'(b));
				slen++;
			end
		end else if (ph == FLD_TRAILER) begin
			if (tpos < TRAILER_LEN && b == (tpos[0] ? SPACE_CODE : ZERO_CODE)) begin
				tpos++;
				if (tpos >= TRAILER_LEN)
					enter_field(FLD_ETX);
			end else begin
				expect_error(b, 32'(b));
			end
		end else if (ph == FLD_ETX) begin
			if (b == ETX_CODE) begin
				enter_field(FLD_HUNT);
				expect_beat(KIND_FRAME, FLD_ETX, '0, 32'(npoints));
			end else begin
				expect_error(b, 32'(b));
			end
		end else begin
			d = hex_digit(b);
			if (d >= 0) begin
				accum = {accum[27:0], 4'(d)};
				if (ndigits < 5'd31)
					ndigits++;
			end else if (b != SPACE_CODE || ndigits == 0) begin
				expect_error(b, 32'(b));
			end else begin
				w   = field_width(ph);
				v   = (w == 32) ? accum : (accum & ((32'd1 << w) - 32'd1));
				idx = elem[9:0];
				accum   = '0;
				ndigits = '0;
				slen    = '0;
				if (ph == FLD_STATUS || ph == FLD_INPUTS || ph == FLD_OUTPUTS) begin
					elem++;
					if (elem >= 2)
						enter_field(ph + 5'd1);
				end else if (ph == FLD_ENCODERS) begin
					if (elem == 0) begin
						enc_on = (v != 0);
						if (enc_on)
							elem = 11'd1;
						else
							enter_field(FLD_CHANNELS);
					end else begin
						elem++;
						if (elem >= 3)
							enter_field(FLD_CHANNELS);
					end
				end else if (ph == FLD_POINT_COUNT) begin
					if (v <= MAX_POINTS) begin
						npoints = v[15:0];
						enter_field((v == 0) ? FLD_TRAILER : FLD_POINTS);
					end
				end else if (ph == FLD_POINTS) begin
					elem++;
					if (elem >= npoints)
						enter_field(FLD_TRAILER);
				end else begin
					enter_field(ph + 5'd1);
				end
				if (ph == FLD_POINT_COUNT && v > MAX_POINTS)
					expect_error(SPACE_CODE, v);
				else
					expect_beat(KIND_NUM, ph, idx, v);
			end
		end
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d (0x%h) actual %0d (0x%h)", $time, what,
				want, want, got, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			errors  = 0;
			npoints = '0;
			enc_on  = 1'b0;
			enter_field(FLD_HUNT);
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// Results first, so a beat never matches an expectation pushed at the same edge.
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: result beat with none expected: kind %0d field %0d index %0d value 0x%h",
						$time, result_kind, field_id, elem_index, value);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					check_field("result_kind", 32'(want.kind), 32'(result_kind));
					check_field("field_id", 32'(want.fid), 32'(field_id));
					check_field("elem_index", 32'(want.idx), 32'(elem_index));
					check_field("value", want.val, value);
				end
			end
			if (in_valid && in_ready)
				predict_byte(byte_in);
			fail_count <= errors;
			pending    <= expected_beats.size();
		end
	end

endmodule

// ===== tb/sv/scan_telegram_parser_test.sv =====
`timescale 1ns / 100ps
// Top of the scan telegram parser testbench: clock, reset, byte stimulus, result sink, verdict.
// Depends on stp_pkg, scan_telegram_parser and the stp_result_check module.

module scan_telegram_parser_test;

	import stp_pkg::*;

	// Rough number of bytes sent over the whole run, the length of the forced result stall,
	// and the settling time after the last expected beat.
	localparam int TOTAL_ITEMS = 1150;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 20;

	typedef enum int {
		FLAW_NONE,
		FLAW_SWAP,
		FLAW_EXTRA_STX,
		FLAW_DROP,
		FLAW_EMPTY,
		FLAW_TRAILER
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  result_kind;
	logic [4:0]  field_id;
	logic [9:0]  elem_index;
	logic [31:0] value;

	int fail_total;
	int pending;

	// Bytes of the telegram being assembled, sent and drained by flush_frame.
	logic [7:0] frame_buf[$];
	int         bytes_sent;

	// When quiet is set neither side idles at random. hold_requests asks the sink for one long stall.
	bit quiet;
	int hold_requests;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	scan_telegram_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_in     (byte_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.field_id    (field_id),
		.elem_index  (elem_index),
		.value       (value)
	);

	stp_result_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_in     (byte_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.field_id    (field_id),
		.elem_index  (elem_index),
		.value       (value),
		.fail_count  (fail_total),
		.pending     (pending)
	);

	// Idle length for either side: mostly none or a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	// Hex digit character for a nibble, letters in either case.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return 8'("0") + 8'(n);
		return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	// Token of random digits, then the separating space.
	function automatic void add_hex_rand(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			add_byte(hex_char(4'($urandom_range(0, 15))));
		add_byte(SPACE_CODE);
	endfunction

	// Token that must carry a chosen value, sometimes with leading zeros.
	function automatic void add_hex_num(input int unsigned v);
		int n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0)
			n++;
		repeat ($urandom_range(0, 2))
			add_byte(ZERO_CODE);
		for (int i = n - 1; i >= 0; i--)
			add_byte(hex_char(4'(v >> (4 * i))));
		add_byte(SPACE_CODE);
	endfunction

	// String token: any byte except the framing characters and the separator.
	function automatic void add_string(input int len);
		logic [7:0] c;
		repeat (len) begin
			c = 8'($urandom_range(0, 255));
			while (c == STX_CODE || c == ETX_CODE || c == SPACE_CODE)
				c = 8'($urandom_range(0, 255));
			add_byte(c);
		end
		add_byte(SPACE_CODE);
	endfunction

	// Sends every byte in frame_buf, one beat per handshake, with random gaps between
	// beats. in_ready is read right after the edge, so it is the value the edge saw.
	// Valid drops at the end before the task returns, so the caller may lower it freely.
	task automatic flush_frame();
		int gap;
		while (frame_buf.size() != 0) begin
			in_valid <= 1'b1;
			byte_in  <= frame_buf.pop_front();
			do
				@(posedge clk);
			while (!in_ready);
			bytes_sent++;
			gap = quiet ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Holds the sender until the checker has seen every expected beat. The first edge
	// lets the expectation of the last accepted byte show up in the count.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Builds one telegram in field order and sends it, optionally damaged:
	// two strings, the sixteen hex tokens of fields 2 to 14, the encoder count (with
	// position and speed when nonzero), channel count, content string, four hex tokens,
	// the point count, the points themselves, the fixed trailer and ETX.
	// A point count at or above the limit is followed by a couple of stray points only.
	task automatic run_telegram(input int len_a, input int len_b, input int len_c,
		input int enc, input int npts, input int dig_lo, input int dig_hi, input flaw_t flaw);
		int start;
		int pos;
		start = frame_buf.size();
		add_byte(STX_CODE);
		add_string(len_a);
		add_string(len_b);
		repeat (16) add_hex_rand(dig_lo, dig_hi);
		add_hex_num(enc);
		if (enc != 0)
			repeat (2) add_hex_rand(dig_lo, dig_hi);
		add_hex_rand(dig_lo, dig_hi);
		add_string(len_c);
		repeat (4) add_hex_rand(dig_lo, dig_hi);
		add_hex_num(npts);
		repeat ((npts >= MAX_POINTS) ? 2 : npts) add_hex_rand(1, 2);
		add_text("0 0 0 0 0 0");
		add_byte(ETX_CODE);

		// Damage sits anywhere after the opening STX; the trailer flaw hits the last
		// twelve bytes, which covers both a trailer mismatch and a wrong closing byte.
		pos = $urandom_range(start + 1, frame_buf.size() - 1);
		case (flaw)
			FLAW_SWAP: begin
				frame_buf[pos] = 8'($urandom_range(0, 255));
			end
			FLAW_EXTRA_STX: begin
				frame_buf.insert(pos, STX_CODE);
			end
			FLAW_DROP: begin
				frame_buf.delete(pos);
			end
			FLAW_EMPTY: begin
				while (pos < frame_buf.size() - 1 && frame_buf[pos] != SPACE_CODE)
					pos++;
				frame_buf.insert(pos, SPACE_CODE);
			end
			FLAW_TRAILER: begin
				pos = $urandom_range(frame_buf.size() - 12, frame_buf.size() - 1);
				frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
			end
			default: begin
			end
		endcase
		flush_frame();
	endtask

	// Result sink. A long stall requested by the stimulus takes precedence; otherwise
	// ready drops at random for gaps drawn like the sender's, unless quiet is set.
	initial begin : result_sink
		int stall;
		int served;
		stall     = 0;
		served    = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served++;
				stall = LONG_HOLD;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int r;
		int la;
		int lb;
		int lc;
		int enc;
		int npts;
		int dig_hi;
		flaw_t flaw;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		byte_in        = 8'h00;
		quiet          = 1'b0;
		hold_requests  = 0;
		bytes_sent     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes outside a telegram are dropped while the parser hunts for STX.
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(ETX_CODE);
		add_byte(SPACE_CODE);
		add_byte(8'h55);
		add_byte(8'hAA);
		add_text("A");
		flush_frame();

		// ETX inside a string is a format error.
		add_byte(STX_CODE);
		add_text("A");
		add_byte(ETX_CODE);
		flush_frame();

		// STX in the middle of a hex token restarts the telegram on the spot; then two
		// empty strings and a byte that is not a hex digit in the version field.
		add_byte(STX_CODE);
		add_text("x y 1");
		add_byte(STX_CODE);
		add_text("  G");
		flush_frame();

		// A second space right after a string end gives an empty hex token.
		add_byte(STX_CODE);
		add_text("a b  ");
		flush_frame();

		// A version token long enough to saturate the digit count keeps only its low bits;
		// the byte after it is not a hex digit.
		add_byte(STX_CODE);
		add_text("a b 0123456789ABCDEF0123456789abcdef0123 x");
		flush_frame();

		// Whole telegrams: the smallest one with empty strings and no points; the longest
		// legal strings with encoders present; an overlong command type; an overlong
		// content string; one point over the limit; a damaged trailer.
		run_telegram(0, 0, 0, 0, 0, 1, 1, FLAW_NONE);
		run_telegram(STRING_MAX - 1, STRING_MAX - 1, STRING_MAX - 1, 3, 3, 1, 2, FLAW_NONE);
		run_telegram(STRING_MAX, 1, 1, 0, 1, 1, 2, FLAW_NONE);
		run_telegram(3, 3, STRING_MAX + 4, 0, 1, 1, 2, FLAW_NONE);
		run_telegram(3, 3, 3, 0, MAX_POINTS + 1, 1, 2, FLAW_NONE);
		run_telegram(3, 3, 3, 2, 5, 1, 2, FLAW_TRAILER);

		// A point count right at the limit is accepted; the telegram then runs out of
		// points, so the trailer is read as points and ETX ends it with an error.
		quiet = 1'b1;
		run_telegram(1, 1, 1, 0, MAX_POINTS, 1, 2, FLAW_NONE);
		quiet = 1'b0;

		// The sender pauses here until all results are in. Then the sink stalls for a long
		// stretch while a telegram streams in, so the internal queue fills and the block
		// has to drop in_ready.
		wait_drained();
		hold_requests++;
		quiet = 1'b1;
		run_telegram(4, 4, 4, 1, 16, 1, 3, FLAW_NONE);
		quiet = 1'b0;
		wait_drained();

		// Random telegrams: most are well formed with random content, the rest carry one
		// flaw, a long or overlong content string or an oversize point count. A few are
		// sent with no idling at all, and now and then the sender waits for the results to drain.
		while (bytes_sent < TOTAL_ITEMS) begin
			r      = $urandom_range(0, 99);
			quiet  = ($urandom_range(0, 5) == 0);
			la     = $urandom_range(0, 8);
			lb     = $urandom_range(0, 8);
			lc     = $urandom_range(0, 8);
			enc    = $urandom_range(0, 3);
			npts   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
			dig_hi = ($urandom_range(0, 15) == 0) ? 34 : 4;
			flaw   = FLAW_NONE;
			if (r < 5)
				lc = $urandom_range(STRING_MAX - 1, STRING_MAX + 2);
			else if (r < 10)
				npts = $urandom_range(MAX_POINTS + 1, 65535);
			else if (r < 40)
				flaw = flaw_t'($urandom_range(1, 5));
			repeat ($urandom_range(0, 2)) begin
				add_byte(8'($urandom_range(0, 255)));
				if (frame_buf[frame_buf.size() - 1] == STX_CODE)
					frame_buf[frame_buf.size() - 1] = 8'hFF;
			end
			run_telegram(la, lb, lc, enc, npts, 1, dig_hi, flaw);
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		quiet = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_total == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
